/* hw/rtl/lbbm_pkg.sv */
// lbbm_pkg: shared types and codes for the lru block buffer manager
// used by lbbm_ctrl, lbbm_dp and lru_block_buffer_manager; no dependencies
package lbbm_pkg;

    localparam int MODE_W  = 3;
    localparam int BLOCK_W = 32;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int ADDR_W  = 22;
    localparam int STAMP_W = 32;

    // command modes
    localparam logic [MODE_W-1:0] MODE_BLOCK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BUFFER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SAVE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EMPTY  = 3'd5;

    // result word kinds
    localparam logic [KIND_W-1:0] KIND_WRITE_BACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_READ,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOOKUP,
        OP_SAVE_STEP,
        OP_WB_VICTIM,
        OP_READ,
        OP_ASSIGN_DONE,
        OP_UPDATE_DONE,
        OP_PLAIN_DONE,
        OP_CLEAR_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic hit;
        logic free_found;
        logic victim_dirty;
    } dp_status_t;

endpackage

/* hw/rtl/lbbm_ctrl.sv */
// lbbm_ctrl: command sequencer for the lru block buffer manager
// depends on lbbm_pkg; drives lbbm_dp through dp_cmd_t, reads dp_status_t
module lbbm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lbbm_pkg::MODE_W-1:0] mode,
    input  lbbm_pkg::dp_status_t        status,
    output lbbm_pkg::dp_cmd_t           cmd,
    output logic                        busy
);
    import lbbm_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic                is_assign;
    logic                need_wb;

    assign is_assign = (mode_reg == MODE_BLOCK) || (mode_reg == MODE_BUFFER);
    assign need_wb   = !status.hit && !status.free_found && status.victim_dirty;
    assign busy      = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_BLOCK;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && start)
            begin
                mode_reg <= mode;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode) inside
                        MODE_BLOCK, MODE_BUFFER, MODE_SAVE, MODE_FLUSH:
                            state_next = ST_SCAN;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = is_assign ? ST_RESOLVE : ST_DONE;
                end
            end
            ST_RESOLVE:
            begin
                // a miss in block mode fetches the block
                if (!status.hit && mode_reg == MODE_BLOCK)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_SCAN:
            begin
                cmd.op = is_assign ? OP_LOOKUP : OP_SAVE_STEP;
            end
            ST_RESOLVE:
            begin
                cmd.op = need_wb ? OP_WB_VICTIM : OP_NONE;
            end
            ST_READ:
            begin
                cmd.op = OP_READ;
            end
            ST_DONE:
            begin
                case (mode_reg) inside
                    MODE_BLOCK, MODE_BUFFER: cmd.op = OP_ASSIGN_DONE;
                    MODE_UPDATE:             cmd.op = OP_UPDATE_DONE;
                    MODE_FLUSH, MODE_EMPTY:  cmd.op = OP_CLEAR_DONE;
                    default:                 cmd.op = OP_PLAIN_DONE;
                endcase
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

/* hw/rtl/lbbm_dp.sv */
// lbbm_dp: slot tag, stamp and flag registers, scan trackers and result register
// depends on lbbm_pkg; commanded by lbbm_ctrl
module lbbm_dp #(
    parameter int SLOTS       = 8,
    parameter int BLOCK_CELLS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lbbm_pkg::dp_cmd_t            cmd,
    output lbbm_pkg::dp_status_t         status,
    input  logic [lbbm_pkg::BLOCK_W-1:0] block_num,
    input  logic                         cfg_valid,
    input  logic [lbbm_pkg::ADDR_W-1:0]  cfg_data,
    output logic                         strobe,
    output logic [lbbm_pkg::KIND_W-1:0]  kind,
    output logic [lbbm_pkg::BLOCK_W-1:0] block_num_out,
    output logic [lbbm_pkg::SLOT_W-1:0]  slot,
    output logic [lbbm_pkg::ADDR_W-1:0]  buffer_address,
    output logic                         last
);
    import lbbm_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    logic [BLOCK_W-1:0] slot_block_reg [SLOTS];
    logic [STAMP_W-1:0] slot_stamp_reg [SLOTS];
    logic [SLOTS-1:0]   slot_valid_reg;
    logic [SLOTS-1:0]   slot_dirty_reg;
    logic [STAMP_W-1:0] counter_reg;
    logic [STAMP_W-1:0] counter_next;
    logic               act_valid_reg;
    logic [SW-1:0]      act_slot_reg;
    logic [ADDR_W-1:0]  base_reg;

    // scan trackers
    logic [BLOCK_W-1:0] blk_reg;
    logic [SW-1:0]      idx_reg;
    logic               hit_reg;
    logic [SW-1:0]      hit_idx_reg;
    logic               free_reg;
    logic [SW-1:0]      free_idx_reg;
    logic [SW-1:0]      min_idx_reg;
    logic [STAMP_W-1:0] min_stamp_reg;
    logic [BLOCK_W-1:0] min_block_reg;

    logic [SW-1:0]      sel;
    logic [SW-1:0]      addr_idx;
    logic [31:0]        offset;
    logic [ADDR_W-1:0]  addr;
    logic [BLOCK_W-1:0] cur_block;
    logic [STAMP_W-1:0] cur_stamp;
    logic               cur_valid;
    logic               cur_dirty;

    assign cur_block = slot_block_reg[idx_reg];
    assign cur_stamp = slot_stamp_reg[idx_reg];
    assign cur_valid = slot_valid_reg[idx_reg];
    assign cur_dirty = slot_dirty_reg[idx_reg];

    assign sel = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : min_idx_reg);

    assign counter_next = (counter_reg == STAMP_MAX) ? STAMP_MAX : counter_reg + 1'b1;

    assign status.scan_last    = (idx_reg == LAST_IDX);
    assign status.hit          = hit_reg;
    assign status.free_found   = free_reg;
    assign status.victim_dirty = slot_dirty_reg[min_idx_reg];

    // slot cell address, one shared multiply by the block size
    always_comb
    begin
        case (cmd.op)
            OP_SAVE_STEP: addr_idx = idx_reg;
            OP_WB_VICTIM: addr_idx = min_idx_reg;
            default:      addr_idx = sel;
        endcase
    end

    assign offset = 32'(addr_idx) * 32'(BLOCK_CELLS);
    assign addr   = base_reg + offset[ADDR_W-1:0];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_valid)
        begin
            base_reg <= cfg_data;
        end
    end

    // block tags hold no reset
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ASSIGN_DONE && !hit_reg)
        begin
            slot_block_reg[sel] <= blk_reg;
        end
    end

    // scan trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
            min_idx_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    idx_reg  <= '0;
                    hit_reg  <= 1'b0;
                    free_reg <= 1'b0;
                end
                OP_LOOKUP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!hit_reg && cur_valid && cur_block == blk_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                    if (!free_reg && !cur_valid)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    // strict compare keeps the lowest index on ties
                    if (idx_reg == '0 || cur_stamp < min_stamp_reg)
                    begin
                        min_idx_reg <= idx_reg;
                    end
                end
                OP_SAVE_STEP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            blk_reg <= block_num;
        end
        if (cmd.op == OP_LOOKUP && (idx_reg == '0 || cur_stamp < min_stamp_reg))
        begin
            min_stamp_reg <= cur_stamp;
            min_block_reg <= cur_block;
        end
    end

    // slot flags, stamps and active slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            slot_dirty_reg <= '0;
            counter_reg    <= '0;
            act_valid_reg  <= 1'b0;
            act_slot_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_stamp_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_SAVE_STEP:
                begin
                    if (cur_valid && cur_dirty)
                    begin
                        slot_dirty_reg[idx_reg] <= 1'b0;
                    end
                end
                OP_WB_VICTIM:
                begin
                    slot_dirty_reg[min_idx_reg] <= 1'b0;
                end
                OP_ASSIGN_DONE:
                begin
                    if (!hit_reg)
                    begin
                        slot_valid_reg[sel] <= 1'b1;
                        slot_dirty_reg[sel] <= 1'b0;
                    end
                    slot_stamp_reg[sel] <= counter_next;
                    counter_reg         <= counter_next;
                    act_valid_reg       <= 1'b1;
                    act_slot_reg        <= sel;
                end
                OP_UPDATE_DONE:
                begin
                    if (act_valid_reg && slot_valid_reg[act_slot_reg])
                    begin
                        slot_dirty_reg[act_slot_reg] <= 1'b1;
                    end
                end
                OP_CLEAR_DONE:
                begin
                    slot_valid_reg <= '0;
                    slot_dirty_reg <= '0;
                    counter_reg    <= '0;
                    act_valid_reg  <= 1'b0;
                    act_slot_reg   <= '0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        slot_stamp_reg[i] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result word strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_SAVE_STEP:   strobe <= cur_valid && cur_dirty;
                OP_WB_VICTIM,
                OP_READ,
                OP_ASSIGN_DONE,
                OP_UPDATE_DONE,
                OP_PLAIN_DONE,
                OP_CLEAR_DONE:  strobe <= 1'b1;
                default:        strobe <= 1'b0;
            endcase
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SAVE_STEP:
            begin
                kind           <= KIND_WRITE_BACK;
                block_num_out  <= cur_block;
                slot           <= SLOT_W'(idx_reg);
                buffer_address <= addr;
                last           <= 1'b0;
            end
            OP_WB_VICTIM:
            begin
                kind           <= KIND_WRITE_BACK;
                block_num_out  <= min_block_reg;
                slot           <= SLOT_W'(min_idx_reg);
                buffer_address <= addr;
                last           <= 1'b0;
            end
            OP_READ:
            begin
                kind           <= KIND_READ;
                block_num_out  <= blk_reg;
                slot           <= SLOT_W'(sel);
                buffer_address <= addr;
                last           <= 1'b0;
            end
            OP_ASSIGN_DONE:
            begin
                kind           <= KIND_DONE;
                block_num_out  <= blk_reg;
                slot           <= SLOT_W'(sel);
                buffer_address <= addr;
                last           <= 1'b1;
            end
            OP_UPDATE_DONE,
            OP_PLAIN_DONE,
            OP_CLEAR_DONE:
            begin
                kind           <= KIND_DONE;
                block_num_out  <= '0;
                slot           <= '0;
                buffer_address <= '0;
                last           <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hw/rtl/lru_block_buffer_manager.sv */
// lru_block_buffer_manager: top level of the lru write-back block buffer manager
// depends on lbbm_pkg, lbbm_ctrl and lbbm_dp
//
// A command (mode, block_num) is taken when start is high and busy is low. Block
// and buffer commands walk the slot registers one slot per clock, resolve the
// slot, issue a read request on a block-mode miss and complete; save and flush
// walk the slots the same way and complete; update, empty and unused modes go
// straight to completion. Every result word is shown for exactly one cycle with
// strobe high and cannot be held off: the receiver must take it then. Result
// words of a command appear in order, the completion (last high) coming as busy
// falls, when the next command may already be started. The user must write the
// base address register via cfg_valid only with no command busy; not enforced.
module lru_block_buffer_manager #(
    parameter int SLOTS       = 8,
    parameter int BLOCK_CELLS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lbbm_pkg::MODE_W-1:0]  mode,
    input  logic [lbbm_pkg::BLOCK_W-1:0] block_num,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lbbm_pkg::ADDR_W-1:0]  cfg_data,
    output logic                         strobe,
    output logic [lbbm_pkg::KIND_W-1:0]  kind,
    output logic [lbbm_pkg::BLOCK_W-1:0] block_num_out,
    output logic [lbbm_pkg::SLOT_W-1:0]  slot,
    output logic [lbbm_pkg::ADDR_W-1:0]  buffer_address,
    output logic                         last
);
    import lbbm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lbbm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lbbm_dp #(
        .SLOTS       (SLOTS),
        .BLOCK_CELLS (BLOCK_CELLS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .block_num      (block_num),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .strobe         (strobe),
        .kind           (kind),
        .block_num_out  (block_num_out),
        .slot           (slot),
        .buffer_address (buffer_address),
        .last           (last)
    );

endmodule
